/* rtl/flqe_pkg.sv */
// ----------------------------------------------------------------------------
// flqe_pkg: shared types and constants of the feathered line quad expander
// Holds the multiplier step count, the micro-operation codes and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package flqe_pkg;

   localparam int MulSteps = 5;      // 8 bits of the b operand per step
   localparam int LastTarget = 3;    // px, py, tx, ty
   localparam logic [3:0] TopBit = 4'd12;
   localparam logic [3:0] LastVertex = 4'd11;
   localparam logic [11:0] FeatherReset = 12'd16;

   typedef enum logic [2:0] {
      OP_SQX,   // adx * adx into the squared length
      OP_SQY,   // ady * ady added to the squared length
      OP_NUM,   // width * delta, the numerator
      OP_LIM,   // numerator squared (times four for the feather targets), the compare limit
      OP_OO,    // odd candidate squared
      OP_T      // odd candidate squared times squared length, then compare
   } op_type;

   typedef struct packed {
      logic       capture;
      logic       classify;
      logic       mul_start;
      logic       mul_run;
      logic       mul_store;
      op_type     op;
      logic [1:0] tgt;
      logic [3:0] bitn;
      logic       load_out;
      logic [3:0] k;
   } cmd_type;

   typedef struct packed {
      logic sloped;
      logic mul_last;
   } status_type;

endpackage

/* rtl/feathered_line_quad_expander.sv */
// ----------------------------------------------------------------------------
// feathered_line_quad_expander: thick line to feathered quad strip expander
// Turns one line segment into twelve vertices: a core band strip and two
// feather band strips whose outer vertices are fully transparent.
// ----------------------------------------------------------------------------
// One segment word is taken at a time. Vertical and horizontal segments go
// through setup (capture, then classify) and then emit their 12 vertex words
// as the output side takes them. A sloped segment first runs its offsets
// through a byte-serial multiplier: 2 products for the squared length and,
// for each of the four offset terms, 2 products plus 13 steps of a rounding
// root search of 2 products each, before its 12 vertex words. The user must
// write the feather width register through the CSR port only while no segment
// is in flight; the block itself does not enforce it.
// Vertex numbering restarts at zero when a segment arrives with its restart
// flag set.
module feathered_line_quad_expander
   import flqe_pkg::*;
#(
   parameter int INDEX_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x[15:0] start_y[31:16] end_x[47:32] end_y[63:48] line_width[76:64]
   // red[84:77] green[92:85] blue[100:93] opacity[108:101], rest zero
   input  logic [111:0] req_tdata,
   // restart[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vert_x[15:0] vert_y[31:16] vert_red[39:32] vert_green[47:40]
   // vert_blue[55:48] vert_alpha[63:56] vertex_index[79:64]
   output logic [79:0]  rsp_tdata,
   // strip_end[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cmd_type    cmd;
   status_type status;
   logic [11:0] feather_ff;

   // The only register, feather_width, sits at byte address 0.
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(feather_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         feather_ff <= FeatherReset;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         feather_ff <= csr_pwdata[11:0];
      end
   end

   flqe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   flqe_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .feather_width (feather_ff),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

/* rtl/flqe_ctrl.sv */
// ----------------------------------------------------------------------------
// flqe_ctrl: sequencer of the feathered line quad expander
// Accepts one segment at a time, walks the multiply and root search
// steps for sloped segments and then emits the twelve vertices.
// ----------------------------------------------------------------------------
module flqe_ctrl
   import flqe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLASS = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   logic [1:0] tgt_ff, tgt_in;
   logic [3:0] bit_ff, bit_in;
   logic [3:0] k_ff, k_in;
   logic       valid_ff, valid_in;
   logic       load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign load = (state_ff == ST_EMIT) && (!valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      tgt_in   = tgt_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (status.sloped) begin
               state_in = ST_LOAD;
               op_in    = OP_SQX;
            end else begin
               state_in = ST_EMIT;
               k_in     = 4'd0;
            end
         end
         ST_LOAD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.mul_last) begin
               state_in = ST_LOAD;
               case (op_ff)
                  OP_SQX: op_in = OP_SQY;
                  OP_SQY: begin
                     op_in  = OP_NUM;
                     tgt_in = 2'd0;
                  end
                  OP_NUM: op_in = OP_LIM;
                  OP_LIM: begin
                     op_in  = OP_OO;
                     bit_in = TopBit;
                  end
                  OP_OO: op_in = OP_T;
                  default: begin
                     if (bit_ff != 4'd0) begin
                        bit_in = bit_ff - 4'd1;
                        op_in  = OP_OO;
                     end else if (tgt_ff != 2'(LastTarget)) begin
                        tgt_in = tgt_ff + 2'd1;
                        op_in  = OP_NUM;
                     end else begin
                        state_in = ST_EMIT;
                        k_in     = 4'd0;
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (load) begin
               k_in = k_ff + 4'd1;
               if (k_ff == LastVertex) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         op_ff    <= OP_SQX;
         tgt_ff   <= 2'd0;
         bit_ff   <= 4'd0;
         k_ff     <= 4'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         op_ff    <= op_in;
         tgt_ff   <= tgt_in;
         bit_ff   <= bit_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      cmd.capture   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.classify  = (state_ff == ST_CLASS);
      cmd.mul_start = (state_ff == ST_LOAD);
      cmd.mul_run   = (state_ff == ST_MUL);
      cmd.mul_store = (state_ff == ST_MUL) && status.mul_last;
      cmd.op        = op_ff;
      cmd.tgt       = tgt_ff;
      cmd.bitn      = bit_ff;
      cmd.load_out  = load;
      cmd.k         = k_ff;
   end

endmodule

/* rtl/flqe_datapath.sv */
// ----------------------------------------------------------------------------
// flqe_datapath: arithmetic of the feathered line quad expander
// Segment registers, a byte-serial multiplier, the rounding root search,
// the offset registers, vertex forming with saturation and the vertex counter.
// ----------------------------------------------------------------------------
module flqe_datapath
   import flqe_pkg::*;
#(
   parameter int INDEX_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  logic [111:0]  req_tdata,
   input  logic          req_tuser,
   input  logic [11:0]   feather_width,
   output logic [79:0]   rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   logic signed [15:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [12:0] lw_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, op_ff;

   logic signed [16:0] dx, dy;
   logic [15:0] adx, ady;
   logic        neg;

   logic [63:0] a_ff, acc_ff, acc_next, mul_a;
   logic [39:0] b_ff, mul_b;
   logic [2:0]  mcnt_ff;

   logic [34:0] sq_ff;
   logic [28:0] num_ff;
   logic [63:0] lim_ff;
   logic [27:0] oo_ff;
   logic [12:0] q_ff, c_ff, c_new, q_new;
   logic [13:0] odd;
   logic [15:0] wsel, adsel;

   logic signed [15:0] nx_ff, ny_ff, mx_ff, my_ff;
   logic [13:0] half;
   logic signed [15:0] qs;

   logic [INDEX_BITS-1:0] cnt_ff;
   logic [31:0] cnt_wide;

   logic signed [18:0] bx, by, vx, vy;
   logic nneg, madd, mneg;
   logic [15:0] satx, saty;

   assign dx  = 17'(ex_ff) - 17'(sx_ff);
   assign dy  = 17'(ey_ff) - 17'(sy_ff);
   assign adx = dx[16] ? 16'(-dx) : dx[15:0];
   assign ady = dy[16] ? 16'(-dy) : dy[15:0];
   assign neg = dx[16] ^ dy[16];
   assign status.sloped = (sx_ff != ex_ff) && (sy_ff != ey_ff);
   assign status.mul_last = (mcnt_ff == 3'(MulSteps - 1));

   assign wsel  = cmd.tgt[1] ? {4'd0, feather_width} : {3'd0, lw_ff};
   assign adsel = cmd.tgt[0] ? adx : ady;
   assign c_new = q_ff | (13'd1 << cmd.bitn);
   assign odd   = {c_new, 1'b0} - 14'd1;

   always_comb begin
      case (cmd.op)
         OP_SQX: begin
            mul_a = 64'(adx);
            mul_b = 40'(adx);
         end
         OP_SQY: begin
            mul_a = 64'(ady);
            mul_b = 40'(ady);
         end
         OP_NUM: begin
            mul_a = 64'(wsel);
            mul_b = 40'(adsel);
         end
         OP_LIM: begin
            mul_a = 64'(num_ff);
            mul_b = 40'(num_ff);
         end
         OP_OO: begin
            mul_a = 64'(odd);
            mul_b = 40'(odd);
         end
         default: begin
            mul_a = 64'(sq_ff);
            mul_b = 40'(oo_ff);
         end
      endcase
   end

   assign acc_next = acc_ff + a_ff * {56'd0, b_ff[7:0]};
   assign q_new = (acc_next <= lim_ff) ? c_ff : q_ff;
   assign qs = 16'(q_new);
   assign half = (14'(lw_ff) + 14'd1) >> 1;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sx_ff    <= req_tdata[15:0];
         sy_ff    <= req_tdata[31:16];
         ex_ff    <= req_tdata[47:32];
         ey_ff    <= req_tdata[63:48];
         lw_ff    <= req_tdata[76:64];
         red_ff   <= req_tdata[84:77];
         green_ff <= req_tdata[92:85];
         blue_ff  <= req_tdata[100:93];
         op_ff    <= req_tdata[108:101];
      end
      if (cmd.classify && !status.sloped) begin
         if (sx_ff == ex_ff) begin
            nx_ff <= -16'(half);
            ny_ff <= 16'd0;
            mx_ff <= -16'(feather_width);
            my_ff <= 16'd0;
         end else begin
            nx_ff <= 16'd0;
            ny_ff <= -16'(half);
            mx_ff <= 16'd0;
            my_ff <= -16'(feather_width);
         end
      end
      if (cmd.mul_start) begin
         a_ff    <= mul_a;
         b_ff    <= mul_b;
         acc_ff  <= 64'd0;
         mcnt_ff <= 3'd0;
         if (cmd.op == OP_NUM) begin
            q_ff <= 13'd0;
         end
         if (cmd.op == OP_OO) begin
            c_ff <= c_new;
         end
      end
      if (cmd.mul_run) begin
         acc_ff  <= acc_next;
         a_ff    <= a_ff << 8;
         b_ff    <= b_ff >> 8;
         mcnt_ff <= mcnt_ff + 3'd1;
      end
      if (cmd.mul_store) begin
         case (cmd.op)
            OP_SQX: sq_ff <= acc_next[34:0];
            OP_SQY: sq_ff <= sq_ff + acc_next[34:0];
            OP_NUM: num_ff <= acc_next[28:0];
            OP_LIM: lim_ff <= cmd.tgt[1] ? (acc_next << 2) : acc_next;
            OP_OO:  oo_ff <= acc_next[27:0];
            default: begin
               q_ff <= q_new;
               if (cmd.bitn == 4'd0) begin
                  case (cmd.tgt)
                     2'd0: nx_ff <= neg ? qs : -qs;
                     2'd1: ny_ff <= qs;
                     2'd2: mx_ff <= neg ? qs : -qs;
                     default: my_ff <= qs;
                  endcase
               end
            end
         endcase
      end
   end

   // Vertex forming: base endpoint, plus or minus the band offset, plus the
   // feather step, added or subtracted, on the outer vertices of the two feather strips.
   always_comb begin
      bx   = cmd.k[1] ? 19'(ex_ff) : 19'(sx_ff);
      by   = cmd.k[1] ? 19'(ey_ff) : 19'(sy_ff);
      nneg = (cmd.k == 4'd1) || (cmd.k == 4'd3) || (cmd.k >= 4'd8);
      madd = (cmd.k >= 4'd4) && cmd.k[0];
      mneg = (cmd.k >= 4'd8);
      vx = nneg ? bx - 19'(nx_ff) : bx + 19'(nx_ff);
      vy = nneg ? by - 19'(ny_ff) : by + 19'(ny_ff);
      if (madd) begin
         vx = mneg ? vx - 19'(mx_ff) : vx + 19'(mx_ff);
         vy = mneg ? vy - 19'(my_ff) : vy + 19'(my_ff);
      end
      if (vx > 19'sd32767) satx = 16'h7FFF;
      else if (vx < -19'sd32768) satx = 16'h8000;
      else satx = vx[15:0];
      if (vy > 19'sd32767) saty = 16'h7FFF;
      else if (vy < -19'sd32768) saty = 16'h8000;
      else saty = vy[15:0];
   end

   assign cnt_wide = 32'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.capture && req_tuser) begin
         cnt_ff <= '0;
      end else if (cmd.load_out) begin
         cnt_ff <= cnt_ff + INDEX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tdata <= {cnt_wide[15:0], (madd ? 8'd0 : op_ff), blue_ff, green_ff,
                       red_ff, saty, satx};
         rsp_tuser <= (cmd.k[1:0] == 2'd3);
         rsp_tlast <= (cmd.k == LastVertex);
      end
   end

endmodule
